[sv/keyed_byte_permutation_unit_assert.svh]
// ----------------------------------------------------------------------------
// Keyed byte permutation unit - assertion macros
// Clocked on clk, disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef KEYED_BYTE_PERMUTATION_UNIT_ASSERT_SVH
`define KEYED_BYTE_PERMUTATION_UNIT_ASSERT_SVH

// same-cycle implication
`define KBP_ASSERT_IMPLIES(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("keyed_byte_permutation_unit: assertion failed");

// next-cycle implication
`define KBP_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("keyed_byte_permutation_unit: assertion failed");

`endif

[sv/kbp_pkg.sv]
// ----------------------------------------------------------------------------
// kbp_pkg
// Types and constants of the keyed byte permutation unit.
// ----------------------------------------------------------------------------
package kbp_pkg;

    localparam logic [31:0] HASH_INIT = 32'h314a_bc86;

    // action codes carried on s_axis_tuser
    localparam logic [2:0] ACT_SEED   = 3'd0;
    localparam logic [2:0] ACT_FINISH = 3'd1;
    localparam logic [2:0] ACT_CLEAR  = 3'd2;
    localparam logic [2:0] ACT_FWD    = 3'd3;
    localparam logic [2:0] ACT_INV    = 3'd4;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LOOKUP,
        ST_EMIT,
        ST_INIT,
        ST_DIV,
        ST_RDI,
        ST_RDJ,
        ST_WRI,
        ST_WRJ,
        ST_INV_RD,
        ST_INV_WR
    } state_t;

endpackage

[sv/keyed_byte_permutation_unit.sv]
// ----------------------------------------------------------------------------
// keyed_byte_permutation_unit
// Keyed byte substitution: seed hash, shuffled table build and lookups.
// ----------------------------------------------------------------------------
// Usage
//   Input stream: s_axis_tuser carries the action, s_axis_tdata the byte.
//   Seed bytes fold into a 32-bit hash; a finish transaction builds the
//   forward and inverse 256-entry tables from it; clear drops the map;
//   forward/inverse transactions translate a byte (pass-through with no map).
//   Every action 0..4 gives one output transaction: m_axis_tdata is the
//   translated byte (zero for other actions), m_axis_tuser the map flag.
//   Action codes 5..7 are accepted and dropped.
// Sequence
//   Seed and clear load the output register directly; lookups go through a registered table read.
//   Finish: 256 table init writes, then 255 swap steps, each a run of the
//   bit-serial remainder unit plus the swap's reads and writes on the
//   single table read port, then a pass filling the inverse table.
//   s_axis_tready is low while a transaction is being worked on.
// Reset / stall
//   rst_n clears the hash to its initial value and drops the map; the
//   tables hold undefined data until a build. One output register sits on
//   the master side; if it is still full the result waits in the block.
// ----------------------------------------------------------------------------
`include "keyed_byte_permutation_unit_assert.svh"

module keyed_byte_permutation_unit
    import kbp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] data_byte
    input  logic [2:0] s_axis_tuser,   // [2:0] action
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,   // [7:0] value
    output logic [0:0] m_axis_tuser    // [0] map_active
);

    function automatic logic [31:0] fold_byte(input logic [31:0] h, input logic [7:0] b);
        logic [31:0] x;
        x = (h * 32'd37) ^ {{24{b[7]}}, b};
        return {x[18:0], x[31:19]};
    endfunction

    function automatic logic [31:0] mix_step(input logic [31:0] s);
        logic [31:0] t;
        t = (s << 1) + s;
        return (t << 13) ^ (t >> 19) ^ (t >> 21);
    endfunction

    state_t      state_reg, state_next;
    logic [31:0] hash_reg, hash_next;
    logic [31:0] gen_reg, gen_next;
    logic        valid_reg, valid_next;
    logic [7:0]  k_reg, k_next;
    logic [7:0]  i_reg, i_next;
    logic [31:0] divq_reg, divq_next;
    logic [7:0]  rem_reg, rem_next;
    logic [4:0]  bit_cnt_reg, bit_cnt_next;
    logic [7:0]  t_reg, t_next;
    logic [7:0]  byte_reg, byte_next;
    logic        look_inv_reg, look_inv_next;
    logic [7:0]  pend_reg, pend_next;
    logic        out_valid_reg, out_valid_next;
    logic [7:0]  out_value_reg, out_value_next;
    logic        out_active_reg, out_active_next;

    logic        out_free;
    logic        out_load;
    logic [7:0]  out_load_value;
    logic [8:0]  trial;
    logic [8:0]  diff;
    logic [7:0]  lookup_value;

    // tables
    logic [7:0]  fwd_mem [256];
    logic [7:0]  inv_mem [256];
    logic        fwd_we, inv_we;
    logic [7:0]  fwd_waddr, fwd_wdata, fwd_raddr, fwd_rdata_reg;
    logic [7:0]  inv_waddr, inv_wdata, inv_rdata_reg;

    always_ff @(posedge clk)
    begin
        if (fwd_we)
        begin
            fwd_mem[fwd_waddr] <= fwd_wdata;
        end
        fwd_rdata_reg <= fwd_mem[fwd_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (inv_we)
        begin
            inv_mem[inv_waddr] <= inv_wdata;
        end
        inv_rdata_reg <= inv_mem[s_axis_tdata];
    end

    // remainder unit: one restoring step a cycle
    assign trial = {rem_reg, divq_reg[31]};
    assign diff  = trial - {1'b0, i_reg};

    assign out_free      = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = (state_reg == ST_IDLE);
    assign lookup_value  = valid_reg ? (look_inv_reg ? inv_rdata_reg : fwd_rdata_reg)
                                     : byte_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            hash_reg      <= HASH_INIT;
            gen_reg       <= 32'd0;
            valid_reg     <= 1'b0;
            k_reg         <= 8'd0;
            i_reg         <= 8'd0;
            rem_reg       <= 8'd0;
            bit_cnt_reg   <= 5'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            hash_reg      <= hash_next;
            gen_reg       <= gen_next;
            valid_reg     <= valid_next;
            k_reg         <= k_next;
            i_reg         <= i_next;
            rem_reg       <= rem_next;
            bit_cnt_reg   <= bit_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        divq_reg       <= divq_next;
        t_reg          <= t_next;
        byte_reg       <= byte_next;
        look_inv_reg   <= look_inv_next;
        pend_reg       <= pend_next;
        out_value_reg  <= out_value_next;
        out_active_reg <= out_active_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        hash_next      = hash_reg;
        gen_next       = gen_reg;
        valid_next     = valid_reg;
        k_next         = k_reg;
        i_next         = i_reg;
        divq_next      = divq_reg;
        rem_next       = rem_reg;
        bit_cnt_next   = bit_cnt_reg;
        t_next         = t_reg;
        byte_next      = byte_reg;
        look_inv_next  = look_inv_reg;
        pend_next      = pend_reg;
        out_load       = 1'b0;
        out_load_value = 8'd0;
        fwd_we         = 1'b0;
        fwd_waddr      = i_reg;
        fwd_wdata      = fwd_rdata_reg;
        fwd_raddr      = s_axis_tdata;
        inv_we         = 1'b0;
        inv_waddr      = fwd_rdata_reg;
        inv_wdata      = k_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    unique case (s_axis_tuser)
                        ACT_SEED:
                        begin
                            if (s_axis_tdata != 8'd0)
                            begin
                                hash_next = fold_byte(hash_reg, s_axis_tdata);
                            end
                            pend_next = 8'd0;
                            if (out_free)
                            begin
                                out_load = 1'b1;
                            end
                            else
                            begin
                                state_next = ST_EMIT;
                            end
                        end
                        ACT_FINISH:
                        begin
                            gen_next   = hash_reg;
                            k_next     = 8'd0;
                            state_next = ST_INIT;
                        end
                        ACT_CLEAR:
                        begin
                            valid_next = 1'b0;
                            pend_next  = 8'd0;
                            if (out_free)
                            begin
                                out_load = 1'b1;
                            end
                            else
                            begin
                                state_next = ST_EMIT;
                            end
                        end
                        ACT_FWD, ACT_INV:
                        begin
                            byte_next     = s_axis_tdata;
                            look_inv_next = (s_axis_tuser == ACT_INV);
                            state_next    = ST_LOOKUP;
                        end
                        default:
                        begin
                            // unused codes: dropped
                        end
                    endcase
                end
            end
            ST_LOOKUP:
            begin
                if (out_free)
                begin
                    out_load       = 1'b1;
                    out_load_value = lookup_value;
                    state_next     = ST_IDLE;
                end
                else
                begin
                    pend_next  = lookup_value;
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    out_load       = 1'b1;
                    out_load_value = pend_reg;
                    state_next     = ST_IDLE;
                end
            end
            ST_INIT:
            begin
                fwd_we    = 1'b1;
                fwd_waddr = k_reg;
                fwd_wdata = k_reg;
                k_next    = k_reg + 8'd1;
                if (k_reg == 8'hFF)
                begin
                    i_next       = 8'hFF;
                    divq_next    = gen_reg;
                    rem_next     = 8'd0;
                    bit_cnt_next = 5'd0;
                    state_next   = ST_DIV;
                end
            end
            ST_DIV:
            begin
                rem_next     = diff[8] ? trial[7:0] : diff[7:0];
                divq_next    = {divq_reg[30:0], 1'b0};
                bit_cnt_next = bit_cnt_reg + 5'd1;
                if (bit_cnt_reg == 5'd31)
                begin
                    gen_next   = mix_step(gen_reg);
                    state_next = ST_RDI;
                end
            end
            ST_RDI:
            begin
                fwd_raddr  = i_reg;
                state_next = ST_RDJ;
            end
            ST_RDJ:
            begin
                fwd_raddr  = rem_reg;
                t_next     = fwd_rdata_reg;
                state_next = ST_WRI;
            end
            ST_WRI:
            begin
                fwd_we     = 1'b1;
                fwd_waddr  = i_reg;
                fwd_wdata  = fwd_rdata_reg;
                state_next = ST_WRJ;
            end
            ST_WRJ:
            begin
                fwd_we    = 1'b1;
                fwd_waddr = rem_reg;
                fwd_wdata = t_reg;
                if (i_reg == 8'd1)
                begin
                    k_next     = 8'd0;
                    state_next = ST_INV_RD;
                end
                else
                begin
                    i_next       = i_reg - 8'd1;
                    divq_next    = gen_reg;
                    rem_next     = 8'd0;
                    bit_cnt_next = 5'd0;
                    state_next   = ST_DIV;
                end
            end
            ST_INV_RD:
            begin
                fwd_raddr  = k_reg;
                state_next = ST_INV_WR;
            end
            ST_INV_WR:
            begin
                inv_we     = 1'b1;
                k_next     = k_reg + 8'd1;
                state_next = ST_INV_RD;
                if (k_reg == 8'hFF)
                begin
                    valid_next = 1'b1;
                    hash_next  = HASH_INIT;
                    pend_next  = 8'd0;
                    if (out_free)
                    begin
                        out_load   = 1'b1;
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        state_next = ST_EMIT;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // output register
        out_valid_next  = out_valid_reg && !m_axis_tready;
        out_value_next  = out_value_reg;
        out_active_next = out_active_reg;
        if (out_load)
        begin
            out_valid_next  = 1'b1;
            out_value_next  = out_load_value;
            out_active_next = valid_next;
        end
    end

    assign m_axis_tvalid   = out_valid_reg;
    assign m_axis_tdata    = out_value_reg;
    assign m_axis_tuser[0] = out_active_reg;

    `KBP_ASSERT_IMPLIES(a_rem_below_divisor, state_reg == ST_DIV, rem_reg < i_reg)
    `KBP_ASSERT_IMPLIES(a_index_nonzero, state_reg == ST_DIV || state_reg == ST_WRJ, i_reg != 8'd0)
    `KBP_ASSERT_NEXT(a_build_sets_map, state_reg == ST_INV_WR && k_reg == 8'hFF, valid_reg)

endmodule

[test/kbp_translation_checker.sv]
// ----------------------------------------------------------------------------
// kbp_translation_checker
// Watches both streams of the keyed byte permutation unit, keeps its own copy
// of the seed hash and of the forward and inverse tables, predicts one result
// per accepted action code 0..4 and compares each output transaction with the oldest
// prediction.
// ----------------------------------------------------------------------------
module kbp_translation_checker
    import kbp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_axis_tvalid,
    input  logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] data_byte
    input  logic [2:0] s_axis_tuser,   // [2:0] action
    input  logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    input  logic [7:0] m_axis_tdata,   // [7:0] value
    input  logic [0:0] m_axis_tuser,   // [0] map_active
    output int         mismatches,
    output int         outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [7:0] value;
        logic       map_active;
    } xlat_result_t;

    xlat_result_t due_results[$];

    logic [31:0] key_hash;
    logic [31:0] shuffle_gen;
    logic [7:0]  fwd_map [256];
    logic [7:0]  inv_map [256];
    logic        map_on;

    // multiply by 37, xor the sign-extended byte, rotate left by 13
    function automatic logic [31:0] fold_seed(logic [31:0] h, logic [7:0] b);
        logic [31:0] m;
        m = (h * 32'd37) ^ {{24{b[7]}}, b};
        return {m[18:0], m[31:19]};
    endfunction

    function automatic void build_permutation();
        logic [31:0] s;
        logic [31:0] j;
        logic [7:0]  t;
        s = key_hash;
        for (int k = 0; k < 256; k++)
            fwd_map[k] = k[7:0];
        for (int unsigned i = 255; i >= 1; i--)
        begin
            j = s % i;
            s = s * 32'd3;
            s = (s << 13) ^ (s >> 19) ^ (s >> 21);
            t = fwd_map[i];
            fwd_map[i] = fwd_map[j[7:0]];
            fwd_map[j[7:0]] = t;
        end
        shuffle_gen = s;
        for (int k = 0; k < 256; k++)
            inv_map[fwd_map[k]] = k[7:0];
        map_on   = 1'b1;
        key_hash = HASH_INIT;
    endfunction

    function automatic void apply_action(logic [2:0] act, logic [7:0] b);
        xlat_result_t r;
        r.value = 8'h00;
        case (act)
            ACT_SEED:
            begin
                // a zero seed byte is skipped and leaves the hash unchanged
                if (b != 8'h00)
                    key_hash = fold_seed(key_hash, b);
            end
            ACT_FINISH: build_permutation();
            ACT_CLEAR:  map_on = 1'b0;
            ACT_FWD:    r.value = map_on ? fwd_map[b] : b;
            ACT_INV:    r.value = map_on ? inv_map[b] : b;
            default:    return;
        endcase
        r.map_active = map_on;
        due_results.push_back(r);
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        xlat_result_t oldest;
        if (!rst_n)
        begin
            key_hash    = HASH_INIT;
            shuffle_gen = 32'h0;
            map_on      = 1'b0;
            mismatches  = 0;
            due_results.delete();
            outstanding <= 0;
        end
        else
        begin
            // results first, so an output in the same cycle as an input
            // cannot be matched against that input's prediction
            if (m_axis_tvalid === 1'b1 && m_axis_tready === 1'b1)
            begin
                if (due_results.size() == 0)
                begin
                    mismatches++;
                    $display("%0t: unexpected result: expected none, actual value %02h map %0b",
                             $time, m_axis_tdata, m_axis_tuser[0]);
                end
                else
                begin
                    oldest = due_results.pop_front();
                    if (m_axis_tdata !== oldest.value)
                    begin
                        mismatches++;
                        $display("%0t: value mismatch: expected %02h, actual %02h",
                                 $time, oldest.value, m_axis_tdata);
                    end
                    if (m_axis_tuser[0] !== oldest.map_active)
                    begin
                        mismatches++;
                        $display("%0t: map_active mismatch: expected %0b, actual %0b",
                                 $time, oldest.map_active, m_axis_tuser[0]);
                    end
                end
            end
            if (s_axis_tvalid === 1'b1 && s_axis_tready === 1'b1)
                apply_action(s_axis_tuser, s_axis_tdata);
            outstanding <= due_results.size();
        end
    end

endmodule

[test/tb.sv]
// ----------------------------------------------------------------------------
// tb
// Drives the keyed byte permutation unit with a directed set of edge cases,
// then with random seed/build/lookup sequences mixed with clears and stray
// codes, random gaps on both streams and occasional drain pauses.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import kbp_pkg::*;

    localparam logic [2:0]  ACT_RSVD_5   = 3'd5;
    localparam logic [2:0]  ACT_RSVD_6   = 3'd6;
    localparam logic [2:0]  ACT_RSVD_7   = 3'd7;
    localparam int          RANDOM_ITEMS = 1500;
    localparam int          DRAIN_EVERY  = 400;
    localparam int unsigned CYCLE_LIMIT  = 4_000_000;

    logic       clk = 1'b0;
    logic       rst_n;
    logic       s_axis_tvalid;
    logic       s_axis_tready;
    logic [7:0] s_axis_tdata;   // [7:0] data_byte
    logic [2:0] s_axis_tuser;   // [2:0] action
    logic       m_axis_tvalid;
    logic       m_axis_tready;
    logic [7:0] m_axis_tdata;   // [7:0] value
    logic [0:0] m_axis_tuser;   // [0] map_active

    int          mismatches;
    int          pending;
    int          sent_by_action [8];
    int          items_sent;
    int          drain_pauses;
    int unsigned cycles = 0;

    always #4ns clk = ~clk;

    keyed_byte_permutation_unit dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    kbp_translation_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .mismatches    (mismatches),
        .outstanding   (pending)
    );

    // mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 98)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [7:0] seed_byte();
        if ($urandom_range(0, 15) == 0)
            return 8'h00;
        return 8'($urandom_range(1, 255));
    endfunction

    function automatic logic [2:0] lookup_action();
        return ($urandom_range(0, 1) != 0) ? ACT_FWD : ACT_INV;
    endfunction

    task automatic send_item(input logic [2:0] act, input logic [7:0] b, input bit calm);
        int gap;
        gap = calm ? 0 : pick_gap();
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= act;
        s_axis_tdata  <= b;
        do
            @(posedge clk);
        while (s_axis_tready !== 1'b1);
        sent_by_action[act]++;
        if (act <= ACT_INV)
            items_sent++;
    endtask

    // hold the sender off until every prediction has been matched
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        drain_pauses++;
    endtask

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // sink side pacing
    initial
    begin : sink_pacing
        int n;
        m_axis_tready = 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if ($urandom_range(0, 9) == 0)
            begin
                m_axis_tready <= 1'b1;
                repeat ($urandom_range(50, 200)) @(posedge clk);
            end
            else
            begin
                n = pick_gap();
                if (n > 0)
                begin
                    m_axis_tready <= 1'b0;
                    repeat (n) @(posedge clk);
                end
                m_axis_tready <= 1'b1;
                repeat ($urandom_range(1, 6)) @(posedge clk);
            end
        end
    end

    initial
    begin : stimulus
        int  kind;
        int  n;
        int  target;
        int  next_drain;
        bit  calm;
        items_sent    = 0;
        drain_pauses  = 0;
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = 8'h00;
        s_axis_tuser  = ACT_SEED;
        foreach (sent_by_action[k])
            sent_by_action[k] = 0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // pass-through before any map exists
        send_item(ACT_FWD, 8'h00, 1'b0);
        send_item(ACT_INV, 8'hff, 1'b0);
        // build from the untouched reset hash
        send_item(ACT_FINISH, 8'hff, 1'b0);
        send_item(ACT_FWD, 8'h00, 1'b0);
        send_item(ACT_FWD, 8'hff, 1'b0);
        send_item(ACT_INV, 8'h00, 1'b0);
        send_item(ACT_INV, 8'hff, 1'b0);
        // zero byte is skipped; sign extension on the top bit
        send_item(ACT_SEED, 8'h00, 1'b0);
        send_item(ACT_SEED, 8'h01, 1'b0);
        send_item(ACT_SEED, 8'h7f, 1'b0);
        send_item(ACT_SEED, 8'h80, 1'b0);
        send_item(ACT_SEED, 8'hff, 1'b0);
        // rebuild over an active map
        send_item(ACT_FINISH, 8'h00, 1'b0);
        send_item(ACT_FWD, 8'h80, 1'b0);
        send_item(ACT_INV, 8'h7f, 1'b0);
        // clear keeps the hash but drops the map
        send_item(ACT_SEED, 8'h42, 1'b0);
        send_item(ACT_CLEAR, 8'hff, 1'b0);
        send_item(ACT_FWD, 8'h12, 1'b0);
        send_item(ACT_INV, 8'h34, 1'b0);
        send_item(ACT_RSVD_5, 8'haa, 1'b0);
        send_item(ACT_RSVD_6, 8'h55, 1'b0);
        send_item(ACT_RSVD_7, 8'hff, 1'b0);
        send_item(ACT_FINISH, 8'h5a, 1'b0);
        send_item(ACT_FWD, 8'h42, 1'b0);
        send_item(ACT_INV, 8'h42, 1'b0);
        drain();

        target     = items_sent + RANDOM_ITEMS;
        next_drain = items_sent + DRAIN_EVERY;
        while (items_sent < target)
        begin
            kind = $urandom_range(0, 99);
            calm = ($urandom_range(0, 5) == 0);
            if (kind < 70)
            begin
                // seed string, build, then a burst of lookups
                repeat ($urandom_range(1, 10)) send_item(ACT_SEED, seed_byte(), calm);
                send_item(ACT_FINISH, 8'($urandom), calm);
                n = $urandom_range(8, 40);
                repeat (n)
                begin
                    if ($urandom_range(0, 19) == 0)
                        send_item(ACT_CLEAR, 8'($urandom), calm);
                    else
                        send_item(lookup_action(), 8'($urandom), calm);
                end
            end
            else if (kind < 90)
            begin
                if ($urandom_range(0, 3) == 0)
                    send_item(ACT_CLEAR, 8'($urandom), calm);
                repeat ($urandom_range(5, 20)) send_item(lookup_action(), 8'($urandom), calm);
            end
            else
            begin
                // broken seed strings and stray codes
                if ($urandom_range(0, 1) != 0)
                begin
                    repeat ($urandom_range(1, 5)) send_item(ACT_SEED, seed_byte(), calm);
                    send_item(ACT_CLEAR, 8'($urandom), calm);
                end
                repeat ($urandom_range(3, 10))
                    send_item(3'($urandom_range(0, 7)), 8'($urandom), calm);
            end
            if (items_sent >= next_drain)
            begin
                drain();
                next_drain += DRAIN_EVERY;
            end
        end

        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (64) @(posedge clk);

        $display("Covered %0d seed, %0d build, %0d clear, %0d forward, %0d inverse transactions",
                 sent_by_action[ACT_SEED], sent_by_action[ACT_FINISH],
                 sent_by_action[ACT_CLEAR], sent_by_action[ACT_FWD], sent_by_action[ACT_INV]);
        $display("plus %0d reserved codes, random gaps on both streams, %0d drain pauses",
                 sent_by_action[ACT_RSVD_5] + sent_by_action[ACT_RSVD_6]
                 + sent_by_action[ACT_RSVD_7], drain_pauses);
        if (mismatches == 0 && pending == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
